// File: hw/rtl/emp_pkg.sv
`default_nettype none

package emp_pkg;

	// Largest matrix order that the index fields can address.
	localparam int unsigned MaxOrder = 64;
	localparam int unsigned PosW     = 6;
	localparam int unsigned AddrW    = 11;
	localparam int unsigned SizeW    = 7;

	// Result queue depth; must be a power of two and at least two.
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned QueueCntW  = QueuePtrW + 1;

	// Register map, indexed by paddr[2].
	localparam logic REG_MATRIX_SIZE  = 1'b0;
	localparam logic REG_SCAN_BY_ROWS = 1'b1;

	localparam logic [SizeW-1:0] MATRIX_SIZE_RESET = SizeW'(MaxOrder);
	localparam logic [SizeW-1:0] MAX_ORDER_C       = SizeW'(MaxOrder);

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_END    = 2'd2
	} emp_kind_t;

	typedef struct packed {
		logic [PosW-1:0] row_index;
		logic [PosW-1:0] col_index;
		logic [31:0]     element_bits;
	} emp_in_t;

	typedef struct packed {
		emp_kind_t        kind;
		logic [PosW-1:0]  line_number;
		logic [31:0]      value_bits;
		logic [AddrW-1:0] address;
		logic [PosW-1:0]  first_position;
		logic             last;
	} emp_out_t;

	typedef struct packed {
		logic [SizeW-1:0] matrix_size;
		logic             scan_by_rows;
	} emp_cfg_t;

	// Up to two results handed together from the packer to the queue.
	typedef struct packed {
		logic [1:0] count;
		emp_out_t   first;
		emp_out_t   second;
	} emp_push_t;

endpackage

`default_nettype wire

// File: hw/rtl/emp_cfg_regs.sv
`default_nettype none

module emp_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output emp_pkg::emp_cfg_t      cfg
);

	emp_pkg::emp_cfg_t cfg_q;
	logic              wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix_size  <= emp_pkg::MATRIX_SIZE_RESET;
			cfg_q.scan_by_rows <= 1'b1;
		end else if (wr_en) begin
			case (paddr[2])
				emp_pkg::REG_MATRIX_SIZE:  cfg_q.matrix_size  <= pwdata[emp_pkg::SizeW-1:0];
				emp_pkg::REG_SCAN_BY_ROWS: cfg_q.scan_by_rows <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			emp_pkg::REG_MATRIX_SIZE:
				prdata = {{(32-emp_pkg::SizeW){1'b0}}, cfg_q.matrix_size};
			emp_pkg::REG_SCAN_BY_ROWS:
				prdata = {31'd0, cfg_q.scan_by_rows};
			default:
				prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/emp_packer.sv
`default_nettype none

module emp_packer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire emp_pkg::emp_cfg_t                   cfg,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire emp_pkg::emp_in_t                    item,
	input  wire logic [emp_pkg::QueueCntW-1:0]       free_slots,
	output emp_pkg::emp_push_t                       push
);

	localparam int unsigned PosW  = emp_pkg::PosW;
	localparam int unsigned AddrW = emp_pkg::AddrW;
	localparam int unsigned SizeW = emp_pkg::SizeW;

	logic             valid_s1;
	emp_pkg::emp_in_t item_s1;

	logic [AddrW-1:0] entry_counter_q;
	logic [AddrW-1:0] line_start_q;
	logic             seen_nonzero_q;
	logic [PosW-1:0]  first_kept_q;

	logic [SizeW-1:0] order;
	logic [PosW-1:0]  line;
	logic [PosW-1:0]  pos;
	logic             is_zero;
	logic             ignore;
	logic             below;
	logic             final_line;
	logic [1:0]       n_res;
	logic             fire_s1;
	logic             accept;

	logic [AddrW-1:0] entry_counter_d;
	logic [AddrW-1:0] line_start_d;
	logic             seen_nonzero_d;
	logic [PosW-1:0]  first_kept_d;

	always_comb begin
		order      = (cfg.matrix_size > emp_pkg::MAX_ORDER_C) ? emp_pkg::MAX_ORDER_C
		                                                      : cfg.matrix_size;
		line       = cfg.scan_by_rows ? item_s1.row_index : item_s1.col_index;
		pos        = cfg.scan_by_rows ? item_s1.col_index : item_s1.row_index;
		is_zero    = (item_s1.element_bits[30:0] == 31'd0);
		ignore     = ({1'b0, line} >= order) || (pos > line);
		below      = (pos < line);
		final_line = ({1'b0, line} + SizeW'(1) == order);

		push.first  = '0;
		push.second = '0;
		n_res       = 2'd0;

		entry_counter_d = entry_counter_q;
		line_start_d    = line_start_q;
		seen_nonzero_d  = seen_nonzero_q;
		first_kept_d    = first_kept_q;

		if (!ignore) begin
			if (below) begin
				if (seen_nonzero_q || !is_zero) begin
					n_res                   = 2'd1;
					push.first.kind         = emp_pkg::KIND_ENTRY;
					push.first.line_number  = line;
					push.first.value_bits   = item_s1.element_bits;
					push.first.address      = entry_counter_q;
					push.first.last         = 1'b1;
					entry_counter_d         = entry_counter_q + AddrW'(1);
					if (!seen_nonzero_q) begin
						seen_nonzero_d = 1'b1;
						first_kept_d   = pos;
					end
				end
			end else begin
				push.first.kind           = emp_pkg::KIND_HEADER;
				push.first.line_number    = line;
				push.first.value_bits     = item_s1.element_bits;
				push.first.address        = line_start_q;
				push.first.first_position = seen_nonzero_q ? first_kept_q : line;
				push.first.last           = !final_line;
				seen_nonzero_d            = 1'b0;
				first_kept_d              = '0;
				if (final_line) begin
					n_res                   = 2'd2;
					push.second.kind        = emp_pkg::KIND_END;
					push.second.line_number = line;
					push.second.address     = entry_counter_q;
					push.second.last        = 1'b1;
					entry_counter_d         = '0;
					line_start_d            = '0;
				end else begin
					n_res        = 2'd1;
					line_start_d = entry_counter_q;
				end
			end
		end

		// The element leaves the input register once the queue can hold all its results.
		fire_s1    = valid_s1 && ({{(emp_pkg::QueueCntW-2){1'b0}}, n_res} <= free_slots);
		push.count = fire_s1 ? n_res : 2'd0;
		item_stall = valid_s1 && !fire_s1;
		accept     = item_valid && !item_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			entry_counter_q <= '0;
			line_start_q    <= '0;
			seen_nonzero_q  <= 1'b0;
			first_kept_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				entry_counter_q <= entry_counter_d;
				line_start_q    <= line_start_d;
				seen_nonzero_q  <= seen_nonzero_d;
				first_kept_q    <= first_kept_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/emp_out_queue.sv
`default_nettype none

module emp_out_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire emp_pkg::emp_push_t            push,
	output logic [emp_pkg::QueueCntW-1:0]      free_slots,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output emp_pkg::emp_out_t                  result
);

	localparam int unsigned PtrW = emp_pkg::QueuePtrW;
	localparam int unsigned CntW = emp_pkg::QueueCntW;

	emp_pkg::emp_out_t slot_q [emp_pkg::QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != '0);
	assign result       = slot_q[rd_ptr_q];
	assign free_slots   = CntW'(emp_pkg::QueueDepth) - count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slot_q[wr_ptr_q + PtrW'(1)] <= push.second;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/envelope_matrix_pack_core.sv
`default_nettype none

// Envelope (skyline) packer for a dense square matrix of IEEE single values.
// Elements enter on the item channel in scan order: row by row when
// scan_by_rows is set (lower triangle kept), column by column otherwise
// (upper triangle kept). Each line yields envelope entries for its positions
// below the diagonal, starting at its first element whose magnitude bits are
// not all zero, and a header when its diagonal element arrives. The header of
// line order-1 (the order is matrix_size capped at 64) is followed by an end
// transaction that carries the total entry count, after which the addresses
// restart for the next matrix. Elements above the diagonal, or in lines at or
// beyond the order, produce nothing. The block takes one item transaction per
// clock cycle while it does not stall the input; an element is held in the
// input register and its results are then written into the result queue,
// which the result channel reads. Throughput is set by the result channel,
// which delivers one transaction per cycle while result_stall is low: the
// final diagonal produces two results and so needs two of its transactions.
// A four-entry result queue absorbs the extra result, but in a gapless stream
// each such diagonal leaves one more result waiting, so the input stalls at
// the third of them unless idle input has let the queue catch up in between.
// A stalled result channel fills the queue and then stalls the input as well.
// Registers (APB, 32-bit): 0x0 matrix_size (7 bits, reset 64),
// 0x4 scan_by_rows (1 bit, reset 1); write them only while the block is idle.
module envelope_matrix_pack_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire emp_pkg::emp_in_t     item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output emp_pkg::emp_out_t         result,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);

	emp_pkg::emp_cfg_t                 cfg;
	emp_pkg::emp_push_t                push;
	logic [emp_pkg::QueueCntW-1:0]     free_slots;

	// Register accesses complete in their access cycle.
	assign pready = 1'b1;

	emp_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Input register, line state and result formation.
	emp_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.free_slots (free_slots),
		.push       (push)
	);

	// Result queue: decouples the result channel's stall from the input side
	// and hands the two results of one push out one at a time.
	emp_out_queue u_out_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.free_slots   (free_slots),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
